### src/meter_readout_frame_deframer_assert.svh
// Assertion macros for the meter readout frame deframer RTL.
`ifndef METER_READOUT_FRAME_DEFRAMER_ASSERT_SVH
`define METER_READOUT_FRAME_DEFRAMER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define MRFD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("frame deframer check failed");

// Next-cycle implication, checked outside reset.
`define MRFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("frame deframer check failed");

`endif

### src/mrfd_pkg.sv
// Types and character constants for the meter readout frame deframer.
package mrfd_pkg;

  localparam logic [6:0] CH_STX   = 7'h02;
  localparam logic [6:0] CH_ETX   = 7'h03;
  localparam logic [6:0] CH_LF    = 7'h0A;
  localparam logic [6:0] CH_BANG  = 7'h21;
  localparam logic [6:0] CH_SLASH = 7'h2F;
  localparam logic [6:0] BYTE_MASK = 7'h7F;

  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  typedef enum logic [1:0] {
    ST_NONE     = 2'd0,
    ST_COMPLETE = 2'd1,
    ST_MISMATCH = 2'd2
  } status_e;

  // Frame tracking state other than the fill count.
  typedef struct packed {
    logic        capturing;
    logic        seen_stx;
    logic        await_check;
    logic        seen_end;
    logic [6:0]  running_check;
    logic        began_slash;
    logic        ident;
    logic [15:0] mismatch_count;
  } state_t;

  // One result item.
  typedef struct packed {
    status_e     status;
    logic [10:0] frame_length;
    logic        check_present;
    logic        check_ok;
    logic        byte_taken;
    logic [6:0]  taken_byte;
    logic [9:0]  taken_index;
    logic        ident_ready;
    logic [15:0] check_errors;
  } result_t;

endpackage

### src/mrfd_step.sv
// Per-byte frame tracking: next state and result for one received byte.
module mrfd_step #(
  parameter int MAX_FRAME = 1024,
  parameter int FillW     = $clog2(MAX_FRAME + 1)
) (
  input  logic [7:0]        rx_byte_i,
  input  mrfd_pkg::state_t  cur_i,
  input  logic [FillW-1:0]  fill_i,
  output mrfd_pkg::state_t  nxt_o,
  output logic [FillW-1:0]  fill_o,
  output mrfd_pkg::result_t res_o
);
  import mrfd_pkg::*;

  localparam logic [FillW-1:0] MaxFill = FillW'(MAX_FRAME);
  localparam logic [FillW-1:0] OneFill = FillW'(1);

  logic [6:0] v;
  logic       ok;
  logic       go;

  assign v  = rx_byte_i[6:0] & BYTE_MASK;
  assign ok = (v == cur_i.running_check);

  always_comb begin
    nxt_o  = cur_i;
    fill_o = fill_i;
    res_o  = '0;
    go     = 1'b0;
    if (cur_i.await_check) begin
      // This byte is the block check character: it closes the frame.
      if (!ok && cur_i.mismatch_count != COUNT_MAX) begin
        nxt_o.mismatch_count = cur_i.mismatch_count + 16'd1;
      end
      res_o.status        = ok ? ST_COMPLETE : ST_MISMATCH;
      res_o.frame_length  = 11'(fill_i);
      res_o.check_present = 1'b1;
      res_o.check_ok      = ok;
      fill_o              = '0;
      nxt_o.capturing     = 1'b0;
      nxt_o.seen_stx      = 1'b0;
      nxt_o.await_check   = 1'b0;
      nxt_o.seen_end      = 1'b0;
      nxt_o.running_check = '0;
      nxt_o.began_slash   = 1'b0;
    end else begin
      go = 1'b1;
      if (!cur_i.capturing) begin
        if (v != CH_SLASH && v != CH_STX) begin
          go = 1'b0;
        end else begin
          nxt_o.capturing = 1'b1;
        end
      end
      if (go && fill_i >= MaxFill) begin
        // Frame overflow: drop the byte and abandon the frame.
        go                  = 1'b0;
        fill_o              = '0;
        nxt_o.capturing     = 1'b0;
        nxt_o.seen_stx      = 1'b0;
        nxt_o.await_check   = 1'b0;
        nxt_o.seen_end      = 1'b0;
        nxt_o.running_check = '0;
        nxt_o.began_slash   = 1'b0;
      end
      if (go) begin
        if (fill_i == '0) begin
          nxt_o.began_slash = (v == CH_SLASH);
        end
        res_o.byte_taken  = 1'b1;
        res_o.taken_byte  = v;
        res_o.taken_index = 10'(fill_i);
        fill_o            = fill_i + OneFill;
        if (v == CH_STX) begin
          nxt_o.seen_stx      = 1'b1;
          nxt_o.running_check = '0;
        end else if (cur_i.seen_stx) begin
          nxt_o.running_check = cur_i.running_check ^ v;
        end
        if (v == CH_BANG) begin
          nxt_o.seen_end = 1'b1;
        end
        if (v == CH_LF && fill_o > OneFill && nxt_o.began_slash && !nxt_o.seen_end) begin
          nxt_o.ident = 1'b1;
        end
        if (v == CH_ETX && nxt_o.seen_stx) begin
          nxt_o.await_check = 1'b1;
        end else if (v == CH_LF && nxt_o.seen_end && !nxt_o.seen_stx) begin
          // Frame without a block check ends on line feed after '!'.
          res_o.status        = ST_COMPLETE;
          res_o.frame_length  = 11'(fill_o);
          res_o.check_present = 1'b0;
          res_o.check_ok      = 1'b1;
          fill_o              = '0;
          nxt_o.capturing     = 1'b0;
          nxt_o.seen_stx      = 1'b0;
          nxt_o.await_check   = 1'b0;
          nxt_o.seen_end      = 1'b0;
          nxt_o.running_check = '0;
          nxt_o.began_slash   = 1'b0;
        end
      end
    end
    res_o.ident_ready  = nxt_o.ident;
    res_o.check_errors = nxt_o.mismatch_count;
  end

endmodule

### src/meter_readout_frame_deframer.sv
// Top level of the meter readout frame deframer: request registers and frame state.
//
// The deframer takes one received byte per request, keeps its low seven bits,
// and tracks a meter readout frame that opens on '/' or STX. Every request
// yields exactly one result: each stored byte comes out with its index so a
// frame memory downstream can hold it, and the closing byte reports the frame
// length and whether the block check matched. The block check is the XOR of
// every byte after STX through ETX; the byte after ETX is compared with it and
// is not stored. A frame without STX ends on line feed once '!' was seen. A
// byte that arrives when MAX_FRAME bytes are already held abandons the frame
// and is dropped. The identification flag is sticky until reset, and the
// mismatch counter saturates at 65535. Throughput is one request per clock
// while the input does not stall: the byte is registered on entry, one short
// pass of logic updates the frame state, and the result register holds it.
// The input stalls only while the result register is full and stalled.
module meter_readout_frame_deframer #(
  parameter int MAX_FRAME = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [10:0] frame_length_o,
  output logic        check_present_o,
  output logic        check_ok_o,
  output logic        byte_taken_o,
  output logic [6:0]  taken_byte_o,
  output logic [9:0]  taken_index_o,
  output logic        ident_ready_o,
  output logic [15:0] check_errors_o
);
  import mrfd_pkg::*;

`include "meter_readout_frame_deframer_assert.svh"

  localparam int FillW = $clog2(MAX_FRAME + 1);
  localparam logic [FillW-1:0] MaxFill = FillW'(MAX_FRAME);

  // Input register.
  logic       in_valid_q;
  logic [7:0] in_byte_q;

  // Frame state.
  state_t           st_q, st_d;
  logic [FillW-1:0] fill_q, fill_d;

  // Result register.
  logic    out_valid_q;
  result_t res_q, res_d;

  logic out_adv;  // result register can take a new result this cycle
  logic proc;     // the registered byte moves into the result register
  logic in_acc;

  assign out_adv    = !out_valid_q || !out_stall_i;
  assign proc       = in_valid_q && out_adv;
  assign in_stall_o = in_valid_q && !out_adv;
  assign in_acc     = in_valid_i && !in_stall_o;

  mrfd_step #(
    .MAX_FRAME(MAX_FRAME),
    .FillW    (FillW)
  ) u_step (
    .rx_byte_i(in_byte_q),
    .cur_i    (st_q),
    .fill_i   (fill_q),
    .nxt_o    (st_d),
    .fill_o   (fill_d),
    .res_o    (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      st_q        <= '0;
      fill_q      <= '0;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (out_adv) begin
        out_valid_q <= in_valid_q;
      end
      if (proc) begin
        st_q   <= st_d;
        fill_q <= fill_d;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_byte_q <= rx_byte_i;
    end
    if (proc) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = res_q.status;
  assign frame_length_o  = res_q.frame_length;
  assign check_present_o = res_q.check_present;
  assign check_ok_o      = res_q.check_ok;
  assign byte_taken_o    = res_q.byte_taken;
  assign taken_byte_o    = res_q.taken_byte;
  assign taken_index_o   = res_q.taken_index;
  assign ident_ready_o   = res_q.ident_ready;
  assign check_errors_o  = res_q.check_errors;

  // A mismatch result always comes from the unstored block check byte.
  `MRFD_ASSERT_NOW(a_mismatch_shape, clk_i, rst_ni, out_valid_q && res_q.status == ST_MISMATCH, !res_q.byte_taken && res_q.check_present && !res_q.check_ok)
  // The fill count never runs past the frame capacity.
  `MRFD_ASSERT_NOW(a_fill_bound, clk_i, rst_ni, 1'b1, fill_q <= MaxFill)
  // The identification flag only clears on reset.
  `MRFD_ASSERT_NEXT(a_ident_sticky, clk_i, rst_ni, st_q.ident, st_q.ident)
  // The mismatch counter never goes down.
  `MRFD_ASSERT_NEXT(a_count_monotonic, clk_i, rst_ni, 1'b1, st_q.mismatch_count >= $past(st_q.mismatch_count))

endmodule
